[hw/rtl/sfes_pkg.sv]
// Shared types, widths and helpers for the state-feedback Euler step block.
// Used by the channel interfaces, the state memory and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sfes_pkg;

  localparam int STATE_COUNT = 4;
  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int IDX_W       = $clog2(STATE_COUNT);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TS_W       = 16;
  localparam logic [TS_W-1:0] TS_RESET = TS_W'(655);

  // Datapath widths; every intermediate is exact up to the rounding points.
  localparam int AS_W   = DATA_WIDTH + FRAC_BITS;
  localparam int BK_W   = 2 * DATA_WIDTH;
  localparam int M_W    = ((AS_W > BK_W) ? AS_W : BK_W) + 1;
  localparam int E_W    = DATA_WIDTH + 1;
  localparam int P_W    = M_W + E_W;
  localparam int ACC_W  = P_W + $clog2(STATE_COUNT);
  localparam int RATE_W = ACC_W + 1 - 2 * FRAC_BITS;
  localparam int TP_W   = RATE_W + TS_W + 1;
  localparam int DL_W   = TP_W + 1 - TS_W;
  localparam int V_W    = DL_W + 1;

  localparam logic [ACC_W:0] RND_ACC = ((ACC_W + 1)'(1) << (2 * FRAC_BITS)) >> 1;
  localparam logic [TP_W:0]  RND_TS  = ((TP_W + 1)'(1) << TS_W) >> 1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]             idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROW0,
    REG_A_ROW1,
    REG_A_ROW2,
    REG_A_ROW3,
    REG_B_COLUMN,
    REG_K_GAINS,
    REG_SETPOINTS,
    REG_SAMPLE_PERIOD
  } cfg_reg_e;

  // Request bundle from the sequencer to the state memory.
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    logic  re;
    idx_t  raddr;
  } mem_req_t;

  // Coefficient j of a packed register sits in bits [16j+15 : 16j].
  function automatic data_t coef(input logic [CFG_DATA_W-1:0] r, input idx_t j);
    return data_t'(r[j*DATA_WIDTH +: DATA_WIDTH]);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sfes_in_if.sv]
// Input channel of the state-feedback Euler step: one measurement beat.
// Depends on sfes_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface sfes_in_if;
  logic            valid;
  logic            ready;
  sfes_pkg::data_t measured_value;
  sfes_pkg::idx_t  in_index;
  sfes_pkg::idx_t  out_index;

  modport source (output valid, measured_value, in_index, out_index, input ready);
  modport sink   (input valid, measured_value, in_index, out_index, output ready);
endinterface

`default_nettype wire

[hw/rtl/sfes_out_if.sv]
// Output channel of the state-feedback Euler step: one result beat.
// Depends on sfes_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface sfes_out_if;
  logic            valid;
  logic            ready;
  sfes_pkg::data_t result;
  logic            saturated;

  modport source (output valid, result, saturated, input ready);
  modport sink   (input valid, result, saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/sfes_state_mem.sv]
// State vector storage: one write port, one read port, registered read data.
// Entries read as zero until first written. Depends on sfes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfes_state_mem (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sfes_pkg::mem_req_t req_i,
  output sfes_pkg::data_t         rd_data_o
);

  sfes_pkg::data_t                    mem_q [sfes_pkg::STATE_COUNT];
  logic [sfes_pkg::STATE_COUNT-1:0]   vld_q;
  sfes_pkg::data_t                    rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q <= vld_q[req_i.raddr] ? mem_q[req_i.raddr] : '0;
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

[hw/rtl/state_feedback_euler_step_top.sv]
// State-feedback Euler step: x' = x + Ts * (A - B*K) * (x - setpoints), saturated.
// A new input beat is accepted only when the sequencer is back in idle; each step runs
// four state reads, 16 issues into one pipelined MAC,
// the pipeline drain, the hand-off to the output register and the idle accept state.
// Reset: the state vector reads as zero, coefficients clear, Ts resets to 655.
`timescale 1ns / 1ps
`default_nettype none

module state_feedback_euler_step_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [sfes_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [sfes_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  sfes_in_if.sink                                   in_i,
  sfes_out_if.source                                out_o
);

  // Sequencer phases. READ copies the state vector out of the memory into a
  // local register file, CALC issues one (row, column) term per cycle into the
  // MAC pipeline, DRAIN waits for the last row to be written back, and DONE
  // hands the result to the output register once it is free.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DRAIN,
    ST_DONE
  } state_e;

  localparam sfes_pkg::idx_t LAST = sfes_pkg::idx_t'(sfes_pkg::STATE_COUNT - 1);

  // Configuration registers.
  logic [sfes_pkg::CFG_DATA_W-1:0] a_row_q [sfes_pkg::STATE_COUNT];
  logic [sfes_pkg::CFG_DATA_W-1:0] b_col_q;
  logic [sfes_pkg::CFG_DATA_W-1:0] k_gain_q;
  logic [sfes_pkg::CFG_DATA_W-1:0] setp_q;
  logic [sfes_pkg::TS_W-1:0]       ts_q;

  // Control.
  state_e          state_q;
  sfes_pkg::idx_t  rcnt_q;
  sfes_pkg::idx_t  iss_i_q;
  sfes_pkg::idx_t  iss_j_q;
  logic            rdv_q;
  sfes_pkg::idx_t  rda_q;
  logic            v1_q, v2_q, v3_q, v4_q, v5_q;
  logic            out_vld_q;

  // Datapath.
  sfes_pkg::data_t                    xcap_q [sfes_pkg::STATE_COUNT];
  sfes_pkg::idx_t                     oidx_q;
  sfes_pkg::idx_t                     i1_q, i2_q, i3_q, i4_q, i5_q;
  logic                               f1_q, f2_q, l1_q, l2_q;
  logic signed [sfes_pkg::BK_W-1:0]   bk1_q;
  logic signed [sfes_pkg::AS_W-1:0]   as1_q;
  logic signed [sfes_pkg::E_W-1:0]    e1_q;
  logic signed [sfes_pkg::P_W-1:0]    prod2_q;
  logic signed [sfes_pkg::ACC_W-1:0]  acc_q;
  logic signed [sfes_pkg::RATE_W-1:0] rate_q;
  logic signed [sfes_pkg::TP_W-1:0]   tp_q;
  logic                               sat_q;
  sfes_pkg::data_t                    res_q;
  sfes_pkg::data_t                    out_res_q;
  logic                               out_sat_q;

  // Combinational nets.
  logic                               in_acc;
  logic                               out_fire;
  logic                               out_load;
  sfes_pkg::mem_req_t                 mem_req;
  sfes_pkg::data_t                    rd_data;
  sfes_pkg::data_t                    a_c, b_c, k_c, sp_c;
  logic signed [sfes_pkg::BK_W-1:0]   bk_d;
  logic signed [sfes_pkg::AS_W-1:0]   as_d;
  logic signed [sfes_pkg::E_W-1:0]    e_d;
  logic signed [sfes_pkg::M_W-1:0]    m_s;
  logic signed [sfes_pkg::P_W-1:0]    prod_d;
  logic signed [sfes_pkg::ACC_W-1:0]  acc_base;
  logic signed [sfes_pkg::ACC_W-1:0]  acc_d;
  logic [sfes_pkg::ACC_W:0]           rsum;
  logic signed [sfes_pkg::RATE_W-1:0] rate_d;
  logic signed [sfes_pkg::TP_W-1:0]   tp_d;
  logic [sfes_pkg::TP_W:0]            tsum;
  logic signed [sfes_pkg::DL_W-1:0]   delta;
  logic signed [sfes_pkg::V_W-1:0]    vsum;
  logic                               fits;
  sfes_pkg::data_t                    wb_val;

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < sfes_pkg::STATE_COUNT; r++) begin
        a_row_q[r] <= '0;
      end
      b_col_q  <= '0;
      k_gain_q <= '0;
      setp_q   <= '0;
      ts_q     <= sfes_pkg::TS_RESET;
    end else if (cfg_we_i) begin
      unique case (sfes_pkg::cfg_reg_e'(cfg_idx_i))
        sfes_pkg::REG_A_ROW0:        a_row_q[0] <= cfg_wdata_i;
        sfes_pkg::REG_A_ROW1:        a_row_q[1] <= cfg_wdata_i;
        sfes_pkg::REG_A_ROW2:        a_row_q[2] <= cfg_wdata_i;
        sfes_pkg::REG_A_ROW3:        a_row_q[3] <= cfg_wdata_i;
        sfes_pkg::REG_B_COLUMN:      b_col_q    <= cfg_wdata_i;
        sfes_pkg::REG_K_GAINS:       k_gain_q   <= cfg_wdata_i;
        sfes_pkg::REG_SETPOINTS:     setp_q     <= cfg_wdata_i;
        sfes_pkg::REG_SAMPLE_PERIOD: ts_q       <= cfg_wdata_i[sfes_pkg::TS_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes. A new beat is taken whenever the sequencer is idle, even while
  // the previous result still sits in the output register.
  assign in_acc   = in_i.valid && (state_q == ST_IDLE);
  assign out_fire = out_vld_q && out_o.ready;
  assign out_load = (state_q == ST_DONE) && (!out_vld_q || out_o.ready);

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_vld_q;
  assign out_o.result    = out_res_q;
  assign out_o.saturated = out_sat_q;

  // The measurement goes into the memory on the accept edge; the read sweep
  // starts the cycle after, so it always sees the new element. Write-back of
  // the updated rows happens only after the sweep has finished, so the error
  // terms of one step never mix old and new state.
  always_comb begin
    mem_req.we    = in_acc || v5_q;
    mem_req.waddr = in_acc ? in_i.in_index : i5_q;
    mem_req.wdata = in_acc ? in_i.measured_value : wb_val;
    mem_req.re    = (state_q == ST_READ);
    mem_req.raddr = rcnt_q;
  end

  sfes_state_mem u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Stage 1: B[i]*K[j], A[i][j] scaled to the product's fraction, error e[j].
  always_comb begin
    a_c  = sfes_pkg::coef(a_row_q[iss_i_q], iss_j_q);
    b_c  = sfes_pkg::coef(b_col_q, iss_i_q);
    k_c  = sfes_pkg::coef(k_gain_q, iss_j_q);
    sp_c = sfes_pkg::coef(setp_q, iss_j_q);
    bk_d = b_c * k_c;
    as_d = sfes_pkg::AS_W'(a_c) <<< sfes_pkg::FRAC_BITS;
    e_d  = sfes_pkg::E_W'(xcap_q[iss_j_q]) - sfes_pkg::E_W'(sp_c);
  end

  // Stage 2: M[i][j] * e[j]. Stage 3: accumulate over the row.
  always_comb begin
    m_s    = sfes_pkg::M_W'(as1_q) - sfes_pkg::M_W'(bk1_q);
    prod_d = m_s * e1_q;
    if (f2_q) begin
      acc_base = '0;
    end else begin
      acc_base = acc_q;
    end
    acc_d = acc_base + sfes_pkg::ACC_W'(prod2_q);
  end

  // Stage 4: round the row sum back to the state fraction (ties go up).
  // Stage 5: scale by Ts. Stage 6: round, add to the old element, clamp.
  always_comb begin
    rsum   = (sfes_pkg::ACC_W + 1)'(acc_q) + sfes_pkg::RND_ACC;
    rate_d = rsum[sfes_pkg::ACC_W:2*sfes_pkg::FRAC_BITS];
    tp_d   = rate_q * $signed({1'b0, ts_q});
    tsum   = (sfes_pkg::TP_W + 1)'(tp_q) + sfes_pkg::RND_TS;
    delta  = tsum[sfes_pkg::TP_W:sfes_pkg::TS_W];
    vsum   = sfes_pkg::V_W'(delta) + sfes_pkg::V_W'(xcap_q[i5_q]);
    fits   = (vsum[sfes_pkg::V_W-1:sfes_pkg::DATA_WIDTH-1] == '0) ||
             (vsum[sfes_pkg::V_W-1:sfes_pkg::DATA_WIDTH-1] == '1);
    if (fits) begin
      wb_val = vsum[sfes_pkg::DATA_WIDTH-1:0];
    end else if (vsum[sfes_pkg::V_W-1]) begin
      wb_val = {1'b1, {(sfes_pkg::DATA_WIDTH-1){1'b0}}};
    end else begin
      wb_val = {1'b0, {(sfes_pkg::DATA_WIDTH-1){1'b1}}};
    end
  end

  // Sequencer, pipeline valids and the output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rcnt_q    <= '0;
      iss_i_q   <= '0;
      iss_j_q   <= '0;
      rdv_q     <= 1'b0;
      rda_q     <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_READ;
            rcnt_q  <= '0;
          end
        end
        ST_READ: begin
          rcnt_q <= rcnt_q + 1'b1;
          if (rcnt_q == LAST) begin
            state_q <= ST_CALC;
            iss_i_q <= '0;
            iss_j_q <= '0;
          end
        end
        ST_CALC: begin
          if (iss_j_q == LAST) begin
            iss_j_q <= '0;
            iss_i_q <= iss_i_q + 1'b1;
            if (iss_i_q == LAST) begin
              state_q <= ST_DRAIN;
            end
          end else begin
            iss_j_q <= iss_j_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (v5_q && (i5_q == LAST)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      rdv_q <= mem_req.re;
      rda_q <= rcnt_q;
      v1_q  <= (state_q == ST_CALC);
      v2_q  <= v1_q;
      v3_q  <= v2_q && l2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_fire) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (rdv_q) begin
      xcap_q[rda_q] <= rd_data;
    end
    if (in_acc) begin
      oidx_q <= in_i.out_index;
    end

    i1_q  <= iss_i_q;
    f1_q  <= (iss_j_q == '0);
    l1_q  <= (iss_j_q == LAST);
    bk1_q <= bk_d;
    as1_q <= as_d;
    e1_q  <= e_d;

    i2_q    <= i1_q;
    f2_q    <= f1_q;
    l2_q    <= l1_q;
    prod2_q <= prod_d;

    if (v2_q) begin
      acc_q <= acc_d;
    end
    i3_q <= i2_q;

    rate_q <= rate_d;
    i4_q   <= i3_q;

    tp_q <= tp_d;
    i5_q <= i4_q;

    if (in_acc) begin
      sat_q <= 1'b0;
    end else if (v5_q) begin
      sat_q <= sat_q | !fits;
    end
    if (v5_q && (i5_q == oidx_q)) begin
      res_q <= wb_val;
    end

    if (out_load) begin
      out_res_q <= res_q;
      out_sat_q <= sat_q;
    end
  end

endmodule

`default_nettype wire
